[rtl/core/qrrs_pkg.sv]
`timescale 1ns / 1ps
package qrrs_pkg;

	// field and datapath widths
	localparam int COEF_W   = 16;
	localparam int PROD_W   = 2 * COEF_W;
	localparam int DISC_W   = PROD_W + 2;
	localparam int SQ_STEPS = DISC_W / 2;
	localparam int ROOT_W   = SQ_STEPS;
	localparam int SQREM_W  = ROOT_W + 1;
	localparam int FRAC_W   = 16;
	localparam int MAG_W    = COEF_W + 1;
	localparam int NUM_W    = MAG_W + FRAC_W;
	localparam int DEN_W    = COEF_W + 1;
	localparam int OUT_W    = 32;

	typedef enum logic [1:0] {
		ST_TWO    = 2'd0,
		ST_DOUBLE = 2'd1,
		ST_NONE   = 2'd2,
		ST_AZERO  = 2'd3
	} status_t;

	// data riding along the square root cells
	typedef struct packed {
		logic               a_zero;
		logic               d_neg;
		logic               d_zero;
		logic [COEF_W-1:0]  a;
		logic [COEF_W-1:0]  b;
	} sq_side_t;

	// data riding along the divider cells
	typedef struct packed {
		status_t            status;
		logic [DEN_W-1:0]   den;
		logic               neg_p;
		logic               neg_m;
	} dv_side_t;

	// one restoring divider lane: dividend shifting out, quotient shifting in
	typedef struct packed {
		logic [NUM_W-1:0]   nq;
		logic [DEN_W-1:0]   rem;
	} dv_lane_t;

endpackage

[rtl/core/qrrs_sqrt_cell.sv]
`timescale 1ns / 1ps
module qrrs_sqrt_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          vld_i,
	input  logic [qrrs_pkg::DISC_W-1:0]   rad_i,
	input  logic [qrrs_pkg::SQREM_W-1:0]  rem_i,
	input  logic [qrrs_pkg::ROOT_W-1:0]   root_i,
	input  qrrs_pkg::sq_side_t            side_i,
	output logic                          vld_o,
	output logic [qrrs_pkg::DISC_W-1:0]   rad_o,
	output logic [qrrs_pkg::SQREM_W-1:0]  rem_o,
	output logic [qrrs_pkg::ROOT_W-1:0]   root_o,
	output qrrs_pkg::sq_side_t            side_o
);
	import qrrs_pkg::*;

	logic [SQREM_W+1:0] remx;
	logic [SQREM_W+1:0] trial;
	logic [SQREM_W+1:0] diff;
	logic               take;
	logic               vld_q;
	logic [DISC_W-1:0]  rad_q;
	logic [SQREM_W-1:0] rem_q;
	logic [ROOT_W-1:0]  root_q;
	sq_side_t           side_q;

	// one root bit: bring down two radicand bits, try root*4+1
	always_comb begin
		remx  = {rem_i, rad_i[DISC_W-1 -: 2]};
		trial = {1'b0, root_i, 2'b01};
		diff  = remx - trial;
		take  = (remx >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		rad_q  <= {rad_i[DISC_W-3:0], 2'b00};
		rem_q  <= take ? diff[SQREM_W-1:0] : remx[SQREM_W-1:0];
		root_q <= {root_i[ROOT_W-2:0], take};
		side_q <= side_i;
	end

	assign vld_o  = vld_q;
	assign rad_o  = rad_q;
	assign rem_o  = rem_q;
	assign root_o = root_q;
	assign side_o = side_q;

endmodule

[rtl/core/qrrs_div_cell.sv]
`timescale 1ns / 1ps
module qrrs_div_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                vld_i,
	input  qrrs_pkg::dv_lane_t  lane_p_i,
	input  qrrs_pkg::dv_lane_t  lane_m_i,
	input  qrrs_pkg::dv_side_t  side_i,
	output logic                vld_o,
	output qrrs_pkg::dv_lane_t  lane_p_o,
	output qrrs_pkg::dv_lane_t  lane_m_o,
	output qrrs_pkg::dv_side_t  side_o
);
	import qrrs_pkg::*;

	logic     vld_q;
	dv_lane_t lane_p_q;
	dv_lane_t lane_m_q;
	dv_side_t side_q;

	// restoring step: one quotient bit
	function automatic dv_lane_t div_step(dv_lane_t l, logic [DEN_W-1:0] den);
		logic [DEN_W:0] remx;
		logic [DEN_W:0] diff;
		dv_lane_t       r;
		remx = {l.rem, l.nq[NUM_W-1]};
		diff = remx - {1'b0, den};
		if (remx >= {1'b0, den}) begin
			r.rem = diff[DEN_W-1:0];
			r.nq  = {l.nq[NUM_W-2:0], 1'b1};
		end else begin
			r.rem = remx[DEN_W-1:0];
			r.nq  = {l.nq[NUM_W-2:0], 1'b0};
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		lane_p_q <= div_step(lane_p_i, side_i.den);
		lane_m_q <= div_step(lane_m_i, side_i.den);
		side_q   <= side_i;
	end

	assign vld_o    = vld_q;
	assign lane_p_o = lane_p_q;
	assign lane_m_o = lane_m_q;
	assign side_o   = side_q;

endmodule

[rtl/core/quadratic_real_root_solver.sv]
`timescale 1ns / 1ps
// Real roots of a*x^2 + b*x + c = 0 for signed Q8.8 coefficients.
// Input channel: coef_a, coef_b, coef_c are taken at a rising edge with start
// high and busy low. busy is always low: one item can enter every cycle.
// Result channel: done is high for exactly one cycle with root_plus, root_minus
// (signed Q16.16, truncated toward zero, clipped to 32 bits), root_status and
// saturated. The receiver cannot hold results off and never needs to.
// The pipeline has one multiply stage (b*b, a*c), one discriminant stage,
// 17 square root cells (one root bit each), one numerator stage, 33 divider
// cells (one quotient bit for both roots each) and one output stage.
// Throughput is one item per cycle; every cell hands its data on each cycle.
// Status: 0 two distinct roots, 1 double root, 2 no real root, 3 a is zero;
// for the last two the roots and saturated are zero.
// Reset clears all valid flags, so no result comes out of a reset pipeline;
// items in flight at reset are dropped.
module quadratic_real_root_solver (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic signed [qrrs_pkg::COEF_W-1:0] coef_a,
	input  logic signed [qrrs_pkg::COEF_W-1:0] coef_b,
	input  logic signed [qrrs_pkg::COEF_W-1:0] coef_c,
	output logic                             done,
	output logic signed [qrrs_pkg::OUT_W-1:0]  root_plus,
	output logic signed [qrrs_pkg::OUT_W-1:0]  root_minus,
	output logic [1:0]                       root_status,
	output logic                             saturated
);
	import qrrs_pkg::*;

	localparam int DV_STEPS = NUM_W;

	// stage 1: products
	logic                      vld_s1;
	logic signed [PROD_W-1:0]  bb_s1;
	logic signed [PROD_W-1:0]  ac_s1;
	logic [COEF_W-1:0]         a_s1;
	logic [COEF_W-1:0]         b_s1;

	// stage 2: discriminant
	logic                      vld_s2;
	logic [DISC_W-1:0]         d_s2;
	sq_side_t                  side_s2;
	logic [DISC_W-1:0]         d_c;

	// square root chain
	logic                      sq_vld  [0:SQ_STEPS];
	logic [DISC_W-1:0]         sq_rad  [0:SQ_STEPS];
	logic [SQREM_W-1:0]        sq_rem  [0:SQ_STEPS];
	logic [ROOT_W-1:0]         sq_root [0:SQ_STEPS];
	sq_side_t                  sq_side [0:SQ_STEPS];

	// stage 3: numerators and divisor
	logic                      vld_s3;
	dv_lane_t                  lane_p_s3;
	dv_lane_t                  lane_m_s3;
	dv_side_t                  dside_s3;
	logic signed [MAG_W:0]     np_c;
	logic signed [MAG_W:0]     nm_c;
	logic signed [MAG_W:0]     npa_c;
	logic signed [MAG_W:0]     nma_c;
	logic signed [DEN_W-1:0]   den2_c;
	logic signed [DEN_W-1:0]   dena_c;
	sq_side_t                  sqe;
	status_t                   st_c;

	// divider chain
	logic                      dv_vld  [0:DV_STEPS];
	dv_lane_t                  dv_lp   [0:DV_STEPS];
	dv_lane_t                  dv_lm   [0:DV_STEPS];
	dv_side_t                  dv_side [0:DV_STEPS];

	// output stage
	logic                      done_q;
	logic [OUT_W-1:0]          rp_q;
	logic [OUT_W-1:0]          rm_q;
	status_t                   st_q;
	logic                      sat_q;
	logic [OUT_W-1:0]          rp_c;
	logic [OUT_W-1:0]          rm_c;
	logic                      cp_c;
	logic                      cm_c;
	logic                      keep_c;

	assign busy = 1'b0;

	// clip a signed magnitude result to 32 bits
	function automatic logic [OUT_W:0] clip(logic [NUM_W-1:0] q, logic neg);
		logic signed [NUM_W:0] v;
		logic [OUT_W:0]        r;
		v = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
		if (!v[NUM_W] && (v[NUM_W-1:OUT_W-1] != '0)) begin
			r = {1'b1, 1'b0, {(OUT_W-1){1'b1}}};
		end else if (v[NUM_W] && (v[NUM_W-1:OUT_W-1] != '1)) begin
			r = {1'b1, 1'b1, {(OUT_W-1){1'b0}}};
		end else begin
			r = {1'b0, v[OUT_W-1:0]};
		end
		return r;
	endfunction

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= sq_vld[SQ_STEPS];
			done_q <= dv_vld[DV_STEPS];
		end
	end

	// products and discriminant
	assign d_c = {{2{bb_s1[PROD_W-1]}}, bb_s1} - {ac_s1, 2'b00};

	always_ff @(posedge clk) begin
		bb_s1          <= coef_b * coef_b;
		ac_s1          <= coef_a * coef_c;
		a_s1           <= coef_a;
		b_s1           <= coef_b;
		d_s2           <= d_c;
		side_s2.a_zero <= (a_s1 == '0);
		side_s2.d_neg  <= d_c[DISC_W-1];
		side_s2.d_zero <= (d_c == '0);
		side_s2.a      <= a_s1;
		side_s2.b      <= b_s1;
	end

	assign sq_vld[0]  = vld_s2;
	assign sq_rad[0]  = d_s2;
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_side[0] = side_s2;

	for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sq
		qrrs_sqrt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.vld_i  (sq_vld[i]),
			.rad_i  (sq_rad[i]),
			.rem_i  (sq_rem[i]),
			.root_i (sq_root[i]),
			.side_i (sq_side[i]),
			.vld_o  (sq_vld[i+1]),
			.rad_o  (sq_rad[i+1]),
			.rem_o  (sq_rem[i+1]),
			.root_o (sq_root[i+1]),
			.side_o (sq_side[i+1])
		);
	end

	// numerators -b +/- s, divisor 2a, signs split off
	always_comb begin
		sqe    = sq_side[SQ_STEPS];
		np_c   = -$signed({{2{sqe.b[COEF_W-1]}}, sqe.b}) + $signed({1'b0, sq_root[SQ_STEPS]});
		nm_c   = -$signed({{2{sqe.b[COEF_W-1]}}, sqe.b}) - $signed({1'b0, sq_root[SQ_STEPS]});
		npa_c  = np_c[MAG_W] ? -np_c : np_c;
		nma_c  = nm_c[MAG_W] ? -nm_c : nm_c;
		den2_c = {sqe.a, 1'b0};
		dena_c = den2_c[DEN_W-1] ? -den2_c : den2_c;
		if (sqe.a_zero) begin
			st_c = ST_AZERO;
		end else if (sqe.d_neg) begin
			st_c = ST_NONE;
		end else if (sqe.d_zero) begin
			st_c = ST_DOUBLE;
		end else begin
			st_c = ST_TWO;
		end
	end

	always_ff @(posedge clk) begin
		lane_p_s3.nq    <= {npa_c[MAG_W-1:0], {FRAC_W{1'b0}}};
		lane_p_s3.rem   <= '0;
		lane_m_s3.nq    <= {nma_c[MAG_W-1:0], {FRAC_W{1'b0}}};
		lane_m_s3.rem   <= '0;
		dside_s3.status <= st_c;
		dside_s3.den    <= dena_c;
		dside_s3.neg_p  <= np_c[MAG_W] ^ sqe.a[COEF_W-1];
		dside_s3.neg_m  <= nm_c[MAG_W] ^ sqe.a[COEF_W-1];
	end

	assign dv_vld[0]  = vld_s3;
	assign dv_lp[0]   = lane_p_s3;
	assign dv_lm[0]   = lane_m_s3;
	assign dv_side[0] = dside_s3;

	for (genvar j = 0; j < DV_STEPS; j++) begin : g_dv
		qrrs_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.vld_i    (dv_vld[j]),
			.lane_p_i (dv_lp[j]),
			.lane_m_i (dv_lm[j]),
			.side_i   (dv_side[j]),
			.vld_o    (dv_vld[j+1]),
			.lane_p_o (dv_lp[j+1]),
			.lane_m_o (dv_lm[j+1]),
			.side_o   (dv_side[j+1])
		);
	end

	// sign, clip, and zero out the no-root cases
	always_comb begin
		{cp_c, rp_c} = clip(dv_lp[DV_STEPS].nq, dv_side[DV_STEPS].neg_p);
		{cm_c, rm_c} = clip(dv_lm[DV_STEPS].nq, dv_side[DV_STEPS].neg_m);
		keep_c = (dv_side[DV_STEPS].status == ST_TWO) ||
		         (dv_side[DV_STEPS].status == ST_DOUBLE);
	end

	always_ff @(posedge clk) begin
		rp_q  <= keep_c ? rp_c : '0;
		rm_q  <= keep_c ? rm_c : '0;
		sat_q <= keep_c && (cp_c || cm_c);
		st_q  <= dv_side[DV_STEPS].status;
	end

	assign done        = done_q;
	assign root_plus   = rp_q;
	assign root_minus  = rm_q;
	assign root_status = st_q;
	assign saturated   = sat_q;

	// no-root cases carry zero roots and no clip flag
	a_noroot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (st_q == ST_NONE || st_q == ST_AZERO)) |->
		(rp_q == '0 && rm_q == '0 && !sat_q))
		else $error("nonzero root with no real root");

	// double root gives equal outputs
	a_double_eq: assert property (@(posedge clk) disable iff (!arst_n)
		(done && st_q == ST_DOUBLE) |-> (rp_q == rm_q))
		else $error("double root outputs differ");

	// every item leaving the root chain reaches the divider input next cycle
	a_chain_hand: assert property (@(posedge clk) disable iff (!arst_n)
		sq_vld[SQ_STEPS] |=> vld_s3)
		else $error("item lost between chains");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
	import qrrs_pkg::*;

	localparam int LATENCY = 54;

	// one expected root set
	typedef struct {
		logic signed [OUT_W-1:0] rp;
		logic signed [OUT_W-1:0] rm;
		status_t                 st;
		logic                    sat;
	} roots_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [COEF_W-1:0] coef_a = '0;
	logic signed [COEF_W-1:0] coef_b = '0;
	logic signed [COEF_W-1:0] coef_c = '0;
	logic done;
	logic signed [OUT_W-1:0] root_plus;
	logic signed [OUT_W-1:0] root_minus;
	logic [1:0] root_status;
	logic saturated;

	roots_t pending_roots[$];
	int errors = 0;

	quadratic_real_root_solver dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.coef_a(coef_a), .coef_b(coef_b), .coef_c(coef_c),
		.done(done), .root_plus(root_plus), .root_minus(root_minus),
		.root_status(root_status), .saturated(saturated)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// floor integer square root, bit by bit
	function automatic longint floor_sqrt(longint v);
		longint r;
		r = 0;
		for (int k = 20; k >= 0; k--) begin
			if ((r + (longint'(1) << k)) * (r + (longint'(1) << k)) <= v)
				r = r + (longint'(1) << k);
		end
		return r;
	endfunction

	function automatic longint clip32(longint v, ref logic sat);
		if (v > 64'sd2147483647) begin
			sat = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			sat = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	// roots of a*x^2 + b*x + c; SV division truncates toward zero
	function automatic roots_t solve_roots(longint a, longint b, longint c);
		roots_t r;
		longint d, s, den;
		logic sat;
		sat = 1'b0;
		r.rp = '0;
		r.rm = '0;
		if (a == 0) begin
			r.st = ST_AZERO;
		end else begin
			d = b * b - 4 * a * c;
			if (d < 0) begin
				r.st = ST_NONE;
			end else begin
				s = floor_sqrt(d);
				den = 2 * a;
				r.rp = 32'(clip32(((-b + s) * 65536) / den, sat));
				if (d == 0) begin
					r.st = ST_DOUBLE;
					r.rm = r.rp;
				end else begin
					r.st = ST_TWO;
					r.rm = 32'(clip32(((-b - s) * 65536) / den, sat));
				end
			end
		end
		r.sat = sat;
		return r;
	endfunction

	// send one item; without keep a one-cycle gap follows
	task automatic send_coefs(input logic [15:0] a, input logic [15:0] b,
			input logic [15:0] c, input bit keep);
		start  <= 1'b1;
		coef_a <= a;
		coef_b <= b;
		coef_c <= c;
		do @(posedge clk); while (busy);
		pending_roots.push_back(solve_roots(longint'($signed(a)),
			longint'($signed(b)), longint'($signed(c))));
		if (!keep) idle_cycles(1);
	endtask

	task automatic idle_cycles(int n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// result checker
	always @(posedge clk) begin
		roots_t e;
		if (arst_n && done) begin
			if (pending_roots.size() == 0) begin
				$display("%0t: unexpected result rp=%0d rm=%0d st=%0d", $time,
					root_plus, root_minus, root_status);
				errors++;
			end else begin
				e = pending_roots.pop_front();
				if (root_plus !== e.rp) begin
					$display("%0t: root_plus exp %0d got %0d", $time, e.rp, root_plus);
					errors++;
				end
				if (root_minus !== e.rm) begin
					$display("%0t: root_minus exp %0d got %0d", $time, e.rm, root_minus);
					errors++;
				end
				if (root_status !== e.st) begin
					$display("%0t: root_status exp %0d got %0d", $time, e.st, root_status);
					errors++;
				end
				if (saturated !== e.sat) begin
					$display("%0t: saturated exp %0d got %0d", $time, e.sat, saturated);
					errors++;
				end
			end
		end
	end

	task automatic test_directed();
		logic [15:0] ext[6];
		ext = '{16'h8000, 16'h7fff, 16'h0000, 16'h0001, 16'hffff, 16'h0100};
		// a zero, negative and zero discriminant, saturation
		send_coefs(16'h0000, 16'h1234, 16'h5678, 1);
		send_coefs(16'h0100, 16'h0000, 16'h0100, 1);
		send_coefs(16'h0100, 16'h0200, 16'h0100, 1);
		send_coefs(16'h0100, 16'h0000, 16'hff00, 1);
		send_coefs(16'h0001, 16'h7fff, 16'h0000, 1);
		send_coefs(16'h0001, 16'h8000, 16'h0000, 1);
		send_coefs(16'hffff, 16'h8000, 16'h7fff, 1);
		send_coefs(16'h8000, 16'h8000, 16'h8000, 1);
		send_coefs(16'h7fff, 16'h7fff, 16'h7fff, 1);
		send_coefs(16'h0001, 16'h0002, 16'h0001, 1);
		foreach (ext[i])
			send_coefs(ext[i], ext[(i + 1) % 6], ext[(i + 3) % 6], i != 5);
		idle_cycles(3);
	endtask

	// random bursts; mostly small a and real-root cases, some full range
	task automatic test_random(int n);
		int burst;
		logic [15:0] a, b, c;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(3))
				0: begin
					a = 16'($urandom);
					b = 16'($urandom);
					c = 16'($urandom);
				end
				1: begin
					a = 16'($signed($urandom_range(16)) - 8);
					b = 16'($urandom);
					c = 16'($urandom_range(255));
				end
				2: begin
					a = 16'($urandom);
					b = 16'($urandom);
					c = 16'(-$signed(16'($urandom_range(4))) * (a[15] ? -1 : 1));
				end
				default: begin
					b = 16'(16'($urandom_range(512)) * 2);
					a = 16'd1 << $urandom_range(6);
					c = 16'(32'(b / 2) * 32'(b / 2) / 32'(a));
				end
			endcase
			burst = $urandom_range(9);
			send_coefs(a, b, c, burst != 0);
			if (burst == 0) idle_cycles($urandom_range(4));
		end
		idle_cycles(1);
	endtask

	// sender holds off until the pipeline has drained
	task automatic test_drain_pause();
		wait (pending_roots.size() == 0);
		@(posedge clk);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_drain_pause();
		test_random(1000);
		test_drain_pause();
		test_random(1000);
		wait (pending_roots.size() == 0);
		repeat (LATENCY + 5) @(posedge clk);
		if (errors == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

	initial begin
		#2000000;
		$display("tb_top NOT OK");
		$finish;
	end

endmodule
